### rtl/core/htherm_pkg.sv
// ----------------------------------------------------------------------------
// htherm_pkg: shared types and constants for the hysteresis thermostat
// Reply codes, frame position codes, character codes and reset values.
// ----------------------------------------------------------------------------
package htherm_pkg;

  typedef enum logic [2:0] {
    RK_NONE    = 3'd0,
    RK_TEMP    = 3'd1,
    RK_RELAY   = 3'd2,
    RK_SETPT   = 3'd3,
    RK_TIME    = 3'd4,
    RK_LOG     = 3'd5,
    RK_ERROR   = 3'd6
  } reply_kind_t;

  // frame position: next command character slot, or no frame open
  typedef enum logic [1:0] {
    FP_CHAR0 = 2'd0,
    FP_CHAR1 = 2'd1,
    FP_CHAR2 = 2'd2,
    FP_IDLE  = 2'd3
  } frame_pos_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_TEMP   = 2'd0,
    CFG_HYSTERESIS = 2'd1,
    CFG_MIN_OFF    = 2'd2,
    CFG_VREF_SCALE = 2'd3
  } cfg_index_t;

  localparam int TempW  = 11;
  localparam int SetptW = 7;
  localparam int SecW   = 32;
  localparam int AdcW   = 10;

  localparam logic signed [TempW-1:0] MaxTempReset = 11'sd55;
  localparam logic [3:0]              HystReset    = 4'd1;
  localparam logic [15:0]             MinOffReset  = 16'd300;
  localparam logic [AdcW-1:0]         VrefReset    = 10'd495;
  localparam logic [SetptW-1:0]       SetptReset   = 7'd30;
  localparam logic signed [TempW-1:0] KelvinOffset = 11'sd273;

  localparam logic [7:0] ChFrame = 8'h66; // 'f'
  localparam logic [7:0] ChG     = 8'h67; // 'g'
  localparam logic [7:0] ChE     = 8'h65; // 'e'
  localparam logic [7:0] ChT     = 8'h74; // 't'
  localparam logic [7:0] ChO     = 8'h6F; // 'o'
  localparam logic [7:0] ChS     = 8'h73; // 's'
  localparam logic [7:0] ChI     = 8'h69; // 'i'
  localparam logic [7:0] ChM     = 8'h6D; // 'm'
  localparam logic [7:0] ChL     = 8'h6C; // 'l'
  localparam logic [7:0] Ch0     = 8'h30; // '0'
  localparam logic [7:0] Ch1     = 8'h31; // '1'
  localparam logic [7:0] Ch9     = 8'h39; // '9'

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= Ch0) && (c <= Ch9);
  endfunction

endpackage

### rtl/core/hysteresis_thermostat_with_command_port.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_with_command_port: bang-bang thermostat with a
// serial command parser. Converts each sample to degrees, parses command
// frames, and switches the relay with a hysteresis band and minimum off time.
// ----------------------------------------------------------------------------
// Each input transaction passes the conversion register, then parse and thermostat
// update into the result register.
// Throughput: one transaction per cycle while the result stream is not stalled;
// the state loop (frame, setpoint, relay, on flag, off time) closes in the second stage.
// Reset (rst, synchronous, active high): no frame open, setpoint 30, relay low,
// on flag clear, off time 0, registers at their default values, pipeline empty.
module hysteresis_thermostat_with_command_port (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // char_byte[7:0], adc_sample[17:8], now_seconds[49:18]
  input  logic [0:0]  s_tuser,   // char_valid[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // relay_level[0], temperature[11:1], setpoint_now[18:12],
                                 // heater_on[19], last_off_time[51:20]
  output logic [2:0]  m_tuser,   // reply_kind[2:0]
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TempW  = htherm_pkg::TempW;
  localparam int SetptW = htherm_pkg::SetptW;
  localparam int SecW   = htherm_pkg::SecW;
  localparam int AdcW   = htherm_pkg::AdcW;

  // --------------------------------------------------------------------------
  // Configuration registers: always ready. The user must see that they are written while
  // the block is idle; the block itself does not enforce it.
  logic signed [TempW-1:0] max_temp;
  logic [3:0]              hysteresis;
  logic [15:0]             min_off_seconds;
  logic [AdcW-1:0]         vref_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_temp        <= htherm_pkg::MaxTempReset;
      hysteresis      <= htherm_pkg::HystReset;
      min_off_seconds <= htherm_pkg::MinOffReset;
      vref_scale      <= htherm_pkg::VrefReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (htherm_pkg::cfg_index_t'(cfg_index))
        htherm_pkg::CFG_MAX_TEMP:   max_temp        <= $signed(cfg_data[TempW-1:0]);
        htherm_pkg::CFG_HYSTERESIS: hysteresis      <= cfg_data[3:0];
        htherm_pkg::CFG_MIN_OFF:    min_off_seconds <= cfg_data;
        htherm_pkg::CFG_VREF_SCALE: vref_scale      <= cfg_data[AdcW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: stage 1 advances whenever the result register is free or drains.
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic s1_proc;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s1_proc  = s1_valid && s1_adv;
  assign s_tready = !s1_valid || s1_adv;

  // --------------------------------------------------------------------------
  // Stage 1: unpack and convert the sample to degrees.
  // --------------------------------------------------------------------------
  logic [2*AdcW-1:0]       adc_prod;
  logic signed [TempW-1:0] temp_in;

  assign adc_prod = s_tdata[17:8] * vref_scale;
  assign temp_in  = $signed({1'b0, adc_prod[2*AdcW-1:AdcW]}) - htherm_pkg::KelvinOffset;

  logic                    s1_char_valid;
  logic [7:0]              s1_char;
  logic signed [TempW-1:0] s1_temp;
  logic [SecW-1:0]         s1_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_char_valid <= s_tuser[0];
      s1_char       <= s_tdata[7:0];
      s1_temp       <= temp_in;
      s1_now        <= s_tdata[49:18];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 state: frame parser and thermostat.
  // --------------------------------------------------------------------------
  htherm_pkg::frame_pos_t frame_pos, frame_pos_next;
  logic [7:0]             cmd0, cmd1;
  logic [SetptW-1:0]      setpoint, setpoint_next;
  logic [SecW-1:0]        off_timestamp, off_timestamp_next;
  logic                   on_flag, on_flag_next;
  logic                   relay_state, relay_state_next;
  htherm_pkg::reply_kind_t reply;

  logic                   run_cmd;
  logic                   relay_cmd;
  logic                   sp_ext_hi_gt, sp_ext_lo_lt;
  logic signed [TempW:0]  temp_ext, sp_hi, sp_lo;
  logic [SecW-1:0]        ready_time;
  logic [SetptW-1:0]      digit_sp;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos     <= htherm_pkg::FP_IDLE;
      setpoint      <= htherm_pkg::SetptReset;
      off_timestamp <= '0;
      on_flag       <= 1'b0;
      relay_state   <= 1'b0;
    end else if (s1_proc) begin
      frame_pos     <= frame_pos_next;
      setpoint      <= setpoint_next;
      off_timestamp <= off_timestamp_next;
      on_flag       <= on_flag_next;
      relay_state   <= relay_state_next;
    end
  end

  // store the first two command characters; the third is used as it arrives
  always_ff @(posedge clk) begin
    if (s1_proc && s1_char_valid && s1_char != htherm_pkg::ChFrame) begin
      if (frame_pos == htherm_pkg::FP_CHAR0) cmd0 <= s1_char;
      if (frame_pos == htherm_pkg::FP_CHAR1) cmd1 <= s1_char;
    end
  end

  assign digit_sp = SetptW'(cmd1[3:0]) * SetptW'(10) + SetptW'(s1_char[3:0]);

  always_comb begin
    frame_pos_next     = frame_pos;
    setpoint_next      = setpoint;
    off_timestamp_next = off_timestamp;
    on_flag_next       = on_flag;
    relay_state_next   = relay_state;
    reply              = htherm_pkg::RK_NONE;
    run_cmd            = 1'b0;
    relay_cmd          = 1'b0;

    // frame parser: 'f' always reopens, other characters fill the open slots
    if (s1_char_valid) begin
      if (s1_char == htherm_pkg::ChFrame) begin
        frame_pos_next = htherm_pkg::FP_CHAR0;
      end else begin
        unique case (frame_pos)
          htherm_pkg::FP_CHAR0: frame_pos_next = htherm_pkg::FP_CHAR1;
          htherm_pkg::FP_CHAR1: frame_pos_next = htherm_pkg::FP_CHAR2;
          htherm_pkg::FP_CHAR2: begin
            frame_pos_next = htherm_pkg::FP_IDLE;
            run_cmd        = 1'b1;
          end
          default: frame_pos_next = htherm_pkg::FP_IDLE;
        endcase
      end
    end

    // execute on the third character of the frame
    if (run_cmd) begin
      unique case (cmd0)
        htherm_pkg::ChG: begin
          if (cmd1 == htherm_pkg::ChE && s1_char == htherm_pkg::ChT) begin
            reply = htherm_pkg::RK_TEMP;
          end
        end
        htherm_pkg::ChO: begin
          if (cmd1 == htherm_pkg::Ch1 &&
              (s1_char == htherm_pkg::Ch0 || s1_char == htherm_pkg::Ch1)) begin
            relay_cmd        = 1'b1;
            relay_state_next = (s1_char == htherm_pkg::Ch1);
            reply            = htherm_pkg::RK_RELAY;
          end
        end
        htherm_pkg::ChS: begin
          if (htherm_pkg::is_digit(cmd1) && htherm_pkg::is_digit(s1_char)) begin
            setpoint_next = digit_sp;
            reply         = htherm_pkg::RK_SETPT;
          end
        end
        htherm_pkg::ChT: begin
          if (cmd1 == htherm_pkg::ChI && s1_char == htherm_pkg::ChM) begin
            reply = htherm_pkg::RK_TIME;
          end
        end
        htherm_pkg::ChL: begin
          if (cmd1 == htherm_pkg::ChO && s1_char == htherm_pkg::ChG) begin
            reply = htherm_pkg::RK_LOG;
          end
        end
        default: reply = htherm_pkg::RK_ERROR;
      endcase
    end

    // thermostat, after any command of the same transaction
    temp_ext     = {s1_temp[TempW-1], s1_temp};
    sp_hi        = $signed({5'b0, setpoint_next} + {8'b0, hysteresis});
    sp_lo        = $signed({5'b0, setpoint_next} - {8'b0, hysteresis});
    sp_ext_hi_gt = temp_ext > sp_hi;
    sp_ext_lo_lt = temp_ext < sp_lo;
    ready_time   = off_timestamp + SecW'(min_off_seconds);

    if (sp_ext_hi_gt) begin
      if (!(ready_time > s1_now) && !(s1_temp > max_temp)) begin
        on_flag_next     = 1'b1;
        relay_state_next = 1'b1;
      end
    end else if (sp_ext_lo_lt) begin
      if (on_flag) begin
        relay_state_next   = 1'b0;
        off_timestamp_next = s1_now;
        on_flag_next       = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold until the downstream side takes the transaction.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_proc) begin
      m_tdata <= {4'b0, off_timestamp_next, on_flag_next, setpoint_next,
                  s1_temp, relay_state_next};
      m_tuser <= reply;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // switching on always drives the relay high
  a_on_relay: assert property (@(posedge clk) disable iff (rst)
    $rose(on_flag) |-> relay_state)
    else $error("on flag set without relay high");

  // switching off drops the relay and stamps the off time
  a_off_stamp: assert property (@(posedge clk) disable iff (rst)
    $fell(on_flag) |-> (!relay_state && off_timestamp == $past(s1_now)))
    else $error("switch-off did not drop relay or record time");

  // thermostat state only moves when a transaction is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_proc |=> $stable({setpoint, on_flag, relay_state, off_timestamp, frame_pos}))
    else $error("state changed without a transaction");

  // a manual relay command only comes with its reply code
  a_relay_reply: assert property (@(posedge clk) disable iff (rst)
    (s1_proc && relay_cmd) |=> (m_tuser == htherm_pkg::RK_RELAY))
    else $error("manual relay command without relay reply");

endmodule
